// ===== hdl/qrav_pkg.sv =====
`timescale 1ns / 1ps
package qrav_pkg;

  // Default widths of the input fields
  localparam int QUAT_BITS_DEF  = 16;
  localparam int EVENT_BITS_DEF = 8;

  // Internal datapath formats
  localparam int NUM_COMP    = 4;                 // w, x, y, z
  localparam int Q15_BITS    = 16;                // signed Q1.15
  localparam int COEF_BITS   = Q15_BITS + 1;      // negated Q1.15 term
  localparam int ACC_A_BITS  = 2 * Q15_BITS + 2;  // sum of four products, Q4.30
  localparam int ISP_BITS    = 24;                // unsigned Q16.8
  localparam int ACC_B_BITS  = ACC_A_BITS + ISP_BITS;
  localparam int RATE_BITS   = 32;                // signed Q16.16
  localparam int ROUND_SHIFT = 21;
  localparam int CNT_BITS    = $clog2((Q15_BITS > ISP_BITS) ? Q15_BITS : ISP_BITS);

  localparam logic [ISP_BITS-1:0]        ISP_RESET = ISP_BITS'(2560);
  localparam logic signed [Q15_BITS-1:0] QUAT_ONE  = {1'b0, {(Q15_BITS-1){1'b1}}};

  // Component slots
  localparam int CW = 0;
  localparam int CX = 1;
  localparam int CY = 2;
  localparam int CZ = 3;

  typedef struct packed {
    logic clear;   // zero the accumulators
    logic step_a;  // one bit of the quaternion product
    logic sign_a;  // current quaternion bit is the sign bit
    logic step_b;  // one bit of the period product
  } ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MULA = 4'b0010,
    ST_MULB = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

endpackage

// ===== hdl/quaternion_rate_to_angular_velocity.sv =====
`timescale 1ns / 1ps
// Flow: a rate item passes the bit-serial quaternion product (ST_MULA), the
//   period product (ST_MULB) and ST_DONE; a restart item (first item or changed
//   event number) goes from ST_IDLE straight to ST_DONE. ST_DONE waits for the
//   output register to be free. A new item is taken only in ST_IDLE.
// Reset (rst_n, synchronous, active low): period register 2560, stored
//   quaternion identity, not primed, no result pending.
module quaternion_rate_to_angular_velocity
  import qrav_pkg::*;
#(
  parameter int QUAT_BITS  = QUAT_BITS_DEF,
  parameter int EVENT_BITS = EVENT_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [QUAT_BITS-1:0] in_quat_w,
  input  logic signed [QUAT_BITS-1:0] in_quat_x,
  input  logic signed [QUAT_BITS-1:0] in_quat_y,
  input  logic signed [QUAT_BITS-1:0] in_quat_z,
  input  logic [EVENT_BITS-1:0]       in_event_number,
  // result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [RATE_BITS-1:0] out_rate_x,
  output logic signed [RATE_BITS-1:0] out_rate_y,
  output logic signed [RATE_BITS-1:0] out_rate_z,
  output logic                        out_rate_valid,
  // configuration
  input  logic                        cfg_wr_en,
  input  logic [ISP_BITS-1:0]         cfg_wr_data
);

  logic                        accept, restart, out_free, idle, done;
  ctl_t                        ctl;

  logic [ISP_BITS-1:0]         isp_r, isp_sh_r;
  logic signed [Q15_BITS-1:0]  prev_r [NUM_COMP];
  logic signed [Q15_BITS-1:0]  qsh_r  [NUM_COMP];
  logic signed [Q15_BITS-1:0]  q_in   [NUM_COMP];
  logic signed [QUAT_BITS-1:0] q_raw  [NUM_COMP];
  logic                        primed_r, restart_r, out_valid_r;
  logic [EVENT_BITS-1:0]       last_event_r;

  logic [NUM_COMP-1:0]         q_bit;
  logic signed [COEF_BITS-1:0] pos [NUM_COMP];
  logic signed [COEF_BITS-1:0] neg [NUM_COMP];
  logic signed [COEF_BITS-1:0] coef_x [NUM_COMP];
  logic signed [COEF_BITS-1:0] coef_y [NUM_COMP];
  logic signed [COEF_BITS-1:0] coef_z [NUM_COMP];
  logic signed [RATE_BITS-1:0] rate_x, rate_y, rate_z;

  assign q_raw[CW] = in_quat_w;
  assign q_raw[CX] = in_quat_x;
  assign q_raw[CY] = in_quat_y;
  assign q_raw[CZ] = in_quat_z;

  // Bring each component to Q1.15: drop low bits of wide inputs, pad narrow ones
  for (genvar k = 0; k < NUM_COMP; k++) begin : g_q15
    if (QUAT_BITS > Q15_BITS) begin : g_wide
      assign q_in[k] = q_raw[k][QUAT_BITS-1 -: Q15_BITS];
    end else if (QUAT_BITS < Q15_BITS) begin : g_narrow
      assign q_in[k] = {q_raw[k], {(Q15_BITS-QUAT_BITS){1'b0}}};
    end else begin : g_same
      assign q_in[k] = q_raw[k];
    end
  end

  assign accept   = in_valid & in_ready;
  assign in_ready = idle;
  // A restart answers zero rate and only reloads the stored quaternion
  assign restart  = !primed_r || (in_event_number != last_event_r);
  assign out_free = !out_valid_r || out_ready;

  qrav_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept),
    .restart  (restart),
    .out_free (out_free),
    .ctl      (ctl),
    .idle     (idle),
    .done     (done)
  );

  // Coefficients come from the stored quaternion p. With d = q - p, the vector
  // part of conj(p) * d reduces to products of p with q, since the p*p terms
  // cancel; q is fed serially, p in parallel.
  always_comb begin
    for (int k = 0; k < NUM_COMP; k++) begin
      pos[k] = COEF_BITS'(prev_r[k]);
      neg[k] = -COEF_BITS'(prev_r[k]);
      q_bit[k] = qsh_r[k][Q15_BITS-1];
    end
    // vx = qw*(-px) + qx*pw + qy*pz + qz*(-py)
    coef_x[CW] = neg[CX]; coef_x[CX] = pos[CW]; coef_x[CY] = pos[CZ]; coef_x[CZ] = neg[CY];
    // vy = qw*(-py) + qx*(-pz) + qy*pw + qz*px
    coef_y[CW] = neg[CY]; coef_y[CX] = neg[CZ]; coef_y[CY] = pos[CW]; coef_y[CZ] = pos[CX];
    // vz = qw*(-pz) + qx*py + qy*(-px) + qz*pw
    coef_z[CW] = neg[CZ]; coef_z[CX] = pos[CY]; coef_z[CY] = neg[CX]; coef_z[CZ] = pos[CW];
  end

  qrav_lane u_lane_x (
    .clk     (clk),
    .ctl     (ctl),
    .q_bit   (q_bit),
    .coef    (coef_x),
    .isp_bit (isp_sh_r[ISP_BITS-1]),
    .rate    (rate_x)
  );

  qrav_lane u_lane_y (
    .clk     (clk),
    .ctl     (ctl),
    .q_bit   (q_bit),
    .coef    (coef_y),
    .isp_bit (isp_sh_r[ISP_BITS-1]),
    .rate    (rate_y)
  );

  qrav_lane u_lane_z (
    .clk     (clk),
    .ctl     (ctl),
    .q_bit   (q_bit),
    .coef    (coef_z),
    .isp_bit (isp_sh_r[ISP_BITS-1]),
    .rate    (rate_z)
  );

  // Control and stored state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      isp_r        <= ISP_RESET;
      primed_r     <= 1'b0;
      last_event_r <= '0;
      restart_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      prev_r[CW]   <= QUAT_ONE;
      prev_r[CX]   <= '0;
      prev_r[CY]   <= '0;
      prev_r[CZ]   <= '0;
    end else begin
      if (cfg_wr_en) begin
        isp_r <= cfg_wr_data;
      end
      if (accept) begin
        primed_r     <= 1'b1;
        last_event_r <= in_event_number;
        restart_r    <= restart;
        if (restart) begin
          prev_r <= q_in;
        end
      end
      if (done) begin
        // the rotating registers are back in place after the full pass
        if (!restart_r) begin
          prev_r <= qsh_r;
        end
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Serial operands: rotate the quaternion, shift out the period MSB first
  always_ff @(posedge clk) begin
    if (accept) begin
      qsh_r    <= q_in;
      isp_sh_r <= isp_r;
    end else begin
      if (ctl.step_a) begin
        for (int k = 0; k < NUM_COMP; k++) begin
          qsh_r[k] <= {qsh_r[k][Q15_BITS-2:0], qsh_r[k][Q15_BITS-1]};
        end
      end
      if (ctl.step_b) begin
        isp_sh_r <= {isp_sh_r[ISP_BITS-2:0], 1'b0};
      end
    end
  end

  // Output register: hold until the transaction completes
  always_ff @(posedge clk) begin
    if (done) begin
      out_rate_x     <= restart_r ? '0 : rate_x;
      out_rate_y     <= restart_r ? '0 : rate_y;
      out_rate_z     <= restart_r ? '0 : rate_z;
      out_rate_valid <= !restart_r;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_busy_after_rate_item: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !restart |=> !in_ready)
    else $error("sequencer took a new item during a rate computation");

  a_primed_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> primed_r && (last_event_r == $past(in_event_number)))
    else $error("event tracking not updated on accept");

  a_restart_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_rate_valid |->
      (out_rate_x == '0) && (out_rate_y == '0) && (out_rate_z == '0))
    else $error("restart result carries nonzero rate");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !done)
    else $error("pending result overwritten");
`endif

endmodule

// ===== hdl/qrav_lane.sv =====
`timescale 1ns / 1ps
module qrav_lane
  import qrav_pkg::*;
(
  input  logic                        clk,
  input  ctl_t                        ctl,
  input  logic [NUM_COMP-1:0]         q_bit,
  input  logic signed [COEF_BITS-1:0] coef [NUM_COMP],
  input  logic                        isp_bit,
  output logic signed [RATE_BITS-1:0] rate
);

  logic signed [ACC_A_BITS-1:0] acc_a_r, acc_a_nxt, pp;
  logic signed [ACC_B_BITS-1:0] acc_b_r, acc_b_nxt, rnd;
  logic [ACC_B_BITS-ROUND_SHIFT-RATE_BITS:0] top_bits;

  // Sum of the selected coefficients for this quaternion bit
  always_comb begin
    pp = '0;
    for (int k = 0; k < NUM_COMP; k++) begin
      if (q_bit[k]) begin
        pp = pp + ACC_A_BITS'(coef[k]);
      end
    end
  end

  // MSB first: the sign bit carries negative weight
  assign acc_a_nxt = (acc_a_r <<< 1) + (ctl.sign_a ? -pp : pp);
  assign acc_b_nxt = (acc_b_r <<< 1) + (isp_bit ? ACC_B_BITS'(acc_a_r) : '0);

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc_a_r <= '0;
      acc_b_r <= '0;
    end else begin
      if (ctl.step_a) begin
        acc_a_r <= acc_a_nxt;
      end
      if (ctl.step_b) begin
        acc_b_r <= acc_b_nxt;
      end
    end
  end

  // Round half up, shift down, saturate
  assign rnd      = acc_b_r + (ACC_B_BITS'(1) <<< (ROUND_SHIFT - 1));
  assign top_bits = rnd[ACC_B_BITS-1:ROUND_SHIFT+RATE_BITS-1];

  always_comb begin
    if ((&top_bits) || !(|top_bits)) begin
      rate = rnd[ROUND_SHIFT+RATE_BITS-1:ROUND_SHIFT];
    end else if (top_bits[ACC_B_BITS-ROUND_SHIFT-RATE_BITS]) begin
      rate = {1'b1, {(RATE_BITS-1){1'b0}}};
    end else begin
      rate = {1'b0, {(RATE_BITS-1){1'b1}}};
    end
  end

endmodule

// ===== hdl/qrav_seq.sv =====
`timescale 1ns / 1ps
module qrav_seq
  import qrav_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic restart,
  input  logic out_free,
  output ctl_t ctl,
  output logic idle,
  output logic done
);

  state_t              state_r, state_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    ctl        = '0;
    done       = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        ctl.clear = start;
        cnt_nxt   = '0;
        if (start) begin
          state_nxt = restart ? ST_DONE : ST_MULA;
        end
      end
      ST_MULA: begin
        ctl.step_a = 1'b1;
        ctl.sign_a = (cnt_r == '0);
        if (cnt_r == CNT_BITS'(Q15_BITS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_MULB;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_MULB: begin
        ctl.step_b = 1'b1;
        if (cnt_r == CNT_BITS'(ISP_BITS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DONE: begin
        done = out_free;
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign idle = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ===== verif/tb_quaternion_rate_to_angular_velocity.sv =====
`timescale 1ns / 1ps
module tb_quaternion_rate_to_angular_velocity;
  import qrav_pkg::*;

  // Run length guard and the quiet time left after each drain.
  // The block answers every transaction, so it is idle once the last rate is out.
  localparam int LIMIT_CYCLES  = 400000;
  localparam int SETTLE_CYCLES = 48;
  localparam int REPORT_MAX    = 10;

  localparam longint RATE_HI = 64'sd2147483647;
  localparam longint RATE_LO = -64'sd2147483648;

  typedef logic signed [QUAT_BITS_DEF-1:0] quat_comp_t;

  // One input transaction: attitude sample plus schedule event.
  // hold_off makes the driver wait until every rate in flight has come back.
  typedef struct packed {
    quat_comp_t                w;
    quat_comp_t                x;
    quat_comp_t                y;
    quat_comp_t                z;
    logic [EVENT_BITS_DEF-1:0] ev;
    logic                      hold_off;
  } attitude_t;

  typedef struct packed {
    logic signed [RATE_BITS-1:0] x;
    logic signed [RATE_BITS-1:0] y;
    logic signed [RATE_BITS-1:0] z;
    logic                        valid;
  } body_rate_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                      in_valid = 1'b0;
  logic                      in_ready;
  quat_comp_t                in_quat_w = '0;
  quat_comp_t                in_quat_x = '0;
  quat_comp_t                in_quat_y = '0;
  quat_comp_t                in_quat_z = '0;
  logic [EVENT_BITS_DEF-1:0] in_event_number = '0;

  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic signed [RATE_BITS-1:0] out_rate_x;
  logic signed [RATE_BITS-1:0] out_rate_y;
  logic signed [RATE_BITS-1:0] out_rate_z;
  logic                        out_rate_valid;

  logic                cfg_wr_en = 1'b0;
  logic [ISP_BITS-1:0] cfg_wr_data = '0;

  quaternion_rate_to_angular_velocity dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_quat_w       (in_quat_w),
    .in_quat_x       (in_quat_x),
    .in_quat_y       (in_quat_y),
    .in_quat_z       (in_quat_z),
    .in_event_number (in_event_number),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_rate_x      (out_rate_x),
    .out_rate_y      (out_rate_y),
    .out_rate_z      (out_rate_z),
    .out_rate_valid  (out_rate_valid),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  // Stimulus waiting for the driver, and rates the block still owes us.
  attitude_t  attitude_queue[$];
  body_rate_t rates_due[$];

  // Predictor state: mirrors the block's stored sample, primed flag, event and period.
  quat_comp_t                prev_quat[4];
  logic                      primed_flag = 1'b0;
  logic [EVENT_BITS_DEF-1:0] last_ev = '0;
  logic [ISP_BITS-1:0]       period_reg = ISP_RESET;

  attitude_t on_wire;
  bit        item_out = 1'b0;    // a transaction is being presented
  bit        idle_on = 1'b1;     // random gaps and stalls allowed
  int        send_gap = 0;
  int        recv_gap = 0;

  int cycle_count = 0;
  int mismatch_count = 0;
  int accepted_count = 0;
  int restart_count = 0;
  int rate_count = 0;
  int sat_count = 0;
  int hold_off_count = 0;
  int period_writes = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    prev_quat[0] = QUAT_ONE;
    prev_quat[1] = '0;
    prev_quat[2] = '0;
    prev_quat[3] = '0;
  end

  // Apply the period (Q16.8), double, and land in Q16.16: one shift by 21,
  // rounding half up, then clamp to the 32-bit range.
  function automatic logic signed [RATE_BITS-1:0] scale_rate(input longint v30);
    longint isp;
    longint r;
    isp = period_reg;
    r = (v30 * isp + (longint'(1) <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
    if (r > RATE_HI) begin
      r = RATE_HI;
      sat_count++;
    end else if (r < RATE_LO) begin
      r = RATE_LO;
      sat_count++;
    end
    return r[RATE_BITS-1:0];
  endfunction

  // Advance the predictor by one sample and return the rate it must produce.
  function automatic body_rate_t differentiate_attitude(input attitude_t a);
    body_rate_t r;
    longint pw, px, py, pz;
    longint dw, dx, dy, dz;
    r = '0;
    if (!primed_flag || a.ev != last_ev) begin
      // Restart: latch the sample and report zero rate, flag clear.
      primed_flag = 1'b1;
      last_ev = a.ev;
      restart_count++;
    end else begin
      pw = prev_quat[0];
      px = prev_quat[1];
      py = prev_quat[2];
      pz = prev_quat[3];
      dw = longint'(a.w) - pw;
      dx = longint'(a.x) - px;
      dy = longint'(a.y) - py;
      dz = longint'(a.z) - pz;
      // Vector part of conj(prev) * delta, Hamilton product, scalar first.
      r.x = scale_rate(pw * dx - dw * px - (py * dz - pz * dy));
      r.y = scale_rate(pw * dy - dw * py - (pz * dx - px * dz));
      r.z = scale_rate(pw * dz - dw * pz - (px * dy - py * dx));
      r.valid = 1'b1;
      rate_count++;
    end
    prev_quat[0] = a.w;
    prev_quat[1] = a.x;
    prev_quat[2] = a.y;
    prev_quat[3] = a.z;
    return r;
  endfunction

  // Driver: predict on every accepted transaction, hold valid until accepted,
  // then pull the next sample after an optional gap.
  always @(posedge clk) begin
    bit fire;
    bit next_valid;
    fire = in_valid && in_ready;
    if (fire) begin
      rates_due.push_back(differentiate_attitude(on_wire));
      accepted_count++;
      item_out = 1'b0;
    end
    next_valid = in_valid && !fire;
    if (rst_n && !next_valid) begin
      if (send_gap != 0) begin
        send_gap--;
      end else if (attitude_queue.size() != 0 &&
                   !(attitude_queue[0].hold_off && rates_due.size() != 0)) begin
        on_wire = attitude_queue.pop_front();
        if (on_wire.hold_off) hold_off_count++;
        in_quat_w       <= on_wire.w;
        in_quat_x       <= on_wire.x;
        in_quat_y       <= on_wire.y;
        in_quat_z       <= on_wire.z;
        in_event_number <= on_wire.ev;
        next_valid = 1'b1;
        item_out = 1'b1;
        if (idle_on && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 16);
      end
    end
    in_valid <= next_valid;
  end

  // Monitor: compare each accepted rate with the oldest prediction; stall at random.
  always @(posedge clk) begin
    body_rate_t want;
    if (rst_n && out_valid && out_ready) begin
      if (rates_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("unexpected rate: x=%0d y=%0d z=%0d valid=%0b",
                   out_rate_x, out_rate_y, out_rate_z, out_rate_valid);
      end else begin
        want = rates_due.pop_front();
        if (out_rate_x !== want.x || out_rate_y !== want.y ||
            out_rate_z !== want.z || out_rate_valid !== want.valid) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("rate mismatch: exp x=%0d y=%0d z=%0d v=%0b, got x=%0d y=%0d z=%0d v=%0b",
                     want.x, want.y, want.z, want.valid,
                     out_rate_x, out_rate_y, out_rate_z, out_rate_valid);
        end
      end
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (recv_gap != 0) begin
      recv_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (idle_on && $urandom_range(0, 7) == 0) recv_gap = $urandom_range(1, 16);
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d rates outstanding", cycle_count, rates_due.size());
      $display("tb_quaternion_rate_to_angular_velocity: errors");
      $finish;
    end
  end

  task automatic add_sample(input int w, input int x, input int y, input int z,
                            input int ev, input bit hold);
    attitude_t a;
    a.w = quat_comp_t'(w);
    a.x = quat_comp_t'(x);
    a.y = quat_comp_t'(y);
    a.z = quat_comp_t'(z);
    a.ev = EVENT_BITS_DEF'(ev);
    a.hold_off = hold;
    attitude_queue.push_back(a);
  endtask

  // Mostly runs that each share one event, with a random-walk attitude, so the block
  // differentiates most of the time; the rest is noise with random events.
  task automatic queue_tracks(input int count);
    int left;
    int run;
    int step;
    logic [EVENT_BITS_DEF-1:0] ev;
    int q[4];
    left = count;
    ev = EVENT_BITS_DEF'($urandom);
    for (int k = 0; k < 4; k++) q[k] = $signed(quat_comp_t'($urandom));
    while (left > 0) begin
      if ($urandom_range(0, 9) == 0) begin
        add_sample($urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom_range(0, 79) == 0);
        left--;
      end else begin
        run = $urandom_range(2, 24);
        if ($urandom_range(0, 3) != 0) ev = EVENT_BITS_DEF'($urandom);
        case ($urandom_range(0, 3))
          0: step = 16;
          1: step = 512;
          2: step = 8192;
          default: step = 32768;
        endcase
        for (int n = 0; n < run && left > 0; n++) begin
          for (int k = 0; k < 4; k++) begin
            q[k] = $signed(quat_comp_t'(q[k] + $urandom_range(0, 2 * step) - step));
            if ($urandom_range(0, 31) == 0) q[k] = $urandom_range(0, 1) ? 32767 : -32768;
          end
          // Break the sequence now and then with a stray event.
          add_sample(q[0], q[1], q[2], q[3],
                     ($urandom_range(0, 19) == 0) ? $urandom : ev,
                     $urandom_range(0, 79) == 0);
          left--;
        end
      end
    end
  endtask

  // Wait until the block owes nothing, then let it settle.
  task automatic drain_block();
    while (attitude_queue.size() != 0 || item_out || rates_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_period(input logic [ISP_BITS-1:0] value);
    drain_block();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    period_reg = value;
    period_writes++;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset period: first sample after reset with event zero, extreme swings,
    // unit axes, repeated sample, event changes to the top and back to zero.
    add_sample(-32768, -32768, -32768, -32768, 0, 0);
    add_sample(32767, 32767, 32767, 32767, 0, 0);
    add_sample(-32768, 32767, -32768, 32767, 0, 0);
    add_sample(32767, 0, 0, 0, 0, 0);
    add_sample(32767, 0, 0, 0, 0, 0);
    add_sample(32138, 6393, 0, 0, 0, 0);
    add_sample(30274, 0, 12540, -1, 0, 0);
    add_sample(32767, 0, 0, 0, 255, 0);
    add_sample(0, 32767, 0, 0, 255, 0);
    add_sample(0, 0, 32767, 0, 255, 0);
    add_sample(0, 0, 0, 32767, 255, 0);
    add_sample(-32768, 0, 0, 0, 255, 0);
    add_sample(0, -32768, 0, 0, 254, 1);
    add_sample(0, 0, -32768, 0, 254, 0);
    add_sample(0, 0, 0, -32768, 254, 0);
    add_sample(16384, 16384, 16384, 16384, 254, 0);
    add_sample(-1, -1, -1, -1, 254, 0);
    add_sample(1, 1, 1, 1, 254, 0);
    add_sample(-1, -1, -1, -1, 0, 0);
    queue_tracks(60);

    // Zero period: every differentiated sample must read zero with the flag set.
    write_period('0);
    queue_tracks(100);

    // Full-scale period: drive the outputs into both saturation limits.
    write_period({ISP_BITS{1'b1}});
    add_sample(32767, 0, 0, 0, 7, 0);
    add_sample(-32768, 32767, -32768, 32767, 7, 0);
    add_sample(32767, -32768, 32767, -32768, 7, 0);
    add_sample(32767, -32767, 32767, -32767, 7, 0);
    queue_tracks(150);

    write_period(ISP_BITS'(1));
    queue_tracks(100);

    write_period(ISP_BITS'($urandom));
    queue_tracks(200);

    // Finish at the reset period with both sides running flat out.
    write_period(ISP_RESET);
    idle_on = 1'b0;
    queue_tracks(250);

    drain_block();

    $display("covered %0d transactions: %0d rates, %0d restarts, %0d clamped components",
             accepted_count, rate_count, restart_count, sat_count);
    $display("periods written %0d, sender held for drain %0d times, %0d cycles",
             period_writes, hold_off_count, cycle_count);
    if (mismatch_count == 0 && rates_due.size() == 0) begin
      $display("tb_quaternion_rate_to_angular_velocity: clean");
    end else begin
      $display("%0d mismatches, %0d rates missing", mismatch_count, rates_due.size());
      $display("tb_quaternion_rate_to_angular_velocity: errors");
    end
    $finish;
  end

endmodule
